// ===== rtl/assert_macros.svh =====
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define C8ID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define C8ID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define C8ID_ASSERT(lbl, prop, msg)
`define C8ID_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/c8id_pkg.sv =====
// Types and constants of the CHIP-8 instruction decoder.
`timescale 1ns / 1ps
package c8id_pkg;

  typedef enum logic [4:0] {
    OP_NOP      = 5'd0,
    OP_ERASE    = 5'd1,
    OP_RETURN   = 5'd2,
    OP_GOTO     = 5'd3,
    OP_CALL     = 5'd4,
    OP_SKE      = 5'd5,
    OP_SKNE     = 5'd6,
    OP_COPY     = 5'd7,
    OP_ADD      = 5'd8,
    OP_OR       = 5'd9,
    OP_AND      = 5'd10,
    OP_XOR      = 5'd11,
    OP_SUB      = 5'd12,
    OP_SETI     = 5'd13,
    OP_GOTOREL  = 5'd14,
    OP_RAND     = 5'd15,
    OP_SHOW     = 5'd16,
    OP_SKE_KEY  = 5'd17,
    OP_SKNE_KEY = 5'd18,
    OP_GETTIME  = 5'd19,
    OP_GETKEY   = 5'd20,
    OP_SETTIME  = 5'd21,
    OP_SETPITCH = 5'd22,
    OP_SETTONE  = 5'd23,
    OP_COPY2    = 5'd24
  } op_e;

  typedef enum logic [3:0] {
    K_NONE  = 4'd0,
    K_REG   = 4'd1,
    K_CONST = 4'd2,
    K_ADDR  = 4'd3,
    K_I     = 4'd4,
    K_KEY   = 4'd5,
    K_TIME  = 4'd6,
    K_PITCH = 4'd7,
    K_TONE  = 4'd8,
    K_MI    = 4'd9,
    K_DIGIT = 4'd10,
    K_DEC   = 4'd11,
    K_RANGE = 4'd12,
    K_RS485 = 4'd13,
    K_BAUD  = 4'd14
  } kind_e;

  // Group nibbles.
  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SEK   = 4'h3;
  localparam logic [3:0] GRP_SNEK  = 4'h4;
  localparam logic [3:0] GRP_SER   = 4'h5;
  localparam logic [3:0] GRP_LDK   = 4'h6;
  localparam logic [3:0] GRP_ADDK  = 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SNER  = 4'h9;
  localparam logic [3:0] GRP_LDI   = 4'hA;
  localparam logic [3:0] GRP_JPV0  = 4'hB;
  localparam logic [3:0] GRP_RND   = 4'hC;
  localparam logic [3:0] GRP_DRW   = 4'hD;
  localparam logic [3:0] GRP_KEY   = 4'hE;

  // Full-word system codes.
  localparam logic [15:0] W_NOP = 16'h0000;
  localparam logic [15:0] W_CLS = 16'h00E0;
  localparam logic [15:0] W_RET = 16'h00EE;

  // ALU sub-codes of group 8.
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;

  // Low-byte codes of groups E and F.
  localparam logic [7:0] LB_SKP   = 8'h9E;
  localparam logic [7:0] LB_SKNP  = 8'hA1;
  localparam logic [7:0] LB_GDT   = 8'h07;
  localparam logic [7:0] LB_GKEY  = 8'h0A;
  localparam logic [7:0] LB_SDT   = 8'h15;
  localparam logic [7:0] LB_PITCH = 8'h17;
  localparam logic [7:0] LB_TONE  = 8'h18;
  localparam logic [7:0] LB_ADDI  = 8'h1E;
  localparam logic [7:0] LB_DIGIT = 8'h29;
  localparam logic [7:0] LB_BCD   = 8'h33;
  localparam logic [7:0] LB_STORE = 8'h55;
  localparam logic [7:0] LB_LOAD  = 8'h65;
  localparam logic [7:0] LB_TX485 = 8'h70;
  localparam logic [7:0] LB_RX485 = 8'h71;
  localparam logic [7:0] LB_BAUD  = 8'h72;

  typedef struct packed {
    logic        valid;
    op_e         op;
    kind_e       k0;
    kind_e       k1;
    kind_e       k2;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [11:0] imm;
  } dec_t;

  localparam dec_t DEC_NONE = '{
    valid: 1'b0, op: OP_NOP, k0: K_NONE, k1: K_NONE, k2: K_NONE,
    x: 4'd0, y: 4'd0, imm: 12'd0
  };

endpackage

// ===== rtl/c8id_decode.sv =====
// Combinational decode of one instruction word.
`timescale 1ns / 1ps
module c8id_decode (
  input  logic [15:0]     word_i,
  output c8id_pkg::dec_t  dec_o
);

  function automatic c8id_pkg::dec_t mk(input c8id_pkg::op_e op,
                                        input c8id_pkg::kind_e k0,
                                        input c8id_pkg::kind_e k1,
                                        input c8id_pkg::kind_e k2);
    c8id_pkg::dec_t d;
    d       = c8id_pkg::DEC_NONE;
    d.valid = 1'b1;
    d.op    = op;
    d.k0    = k0;
    d.k1    = k1;
    d.k2    = k2;
    return d;
  endfunction

  logic [3:0]  grp, x, y, n;
  logic [7:0]  kk;
  logic [11:0] nnn;

  assign grp = word_i[15:12];
  assign x   = word_i[11:8];
  assign y   = word_i[7:4];
  assign n   = word_i[3:0];
  assign kk  = word_i[7:0];
  assign nnn = word_i[11:0];

  always_comb begin
    dec_o = c8id_pkg::DEC_NONE;
    unique case (grp)
      c8id_pkg::GRP_SYS: begin
        if (word_i == c8id_pkg::W_NOP) begin
          dec_o = mk(c8id_pkg::OP_NOP, c8id_pkg::K_NONE, c8id_pkg::K_NONE, c8id_pkg::K_NONE);
        end else if (word_i == c8id_pkg::W_CLS) begin
          dec_o = mk(c8id_pkg::OP_ERASE, c8id_pkg::K_NONE, c8id_pkg::K_NONE,
                     c8id_pkg::K_NONE);
        end else if (word_i == c8id_pkg::W_RET) begin
          dec_o = mk(c8id_pkg::OP_RETURN, c8id_pkg::K_NONE, c8id_pkg::K_NONE,
                     c8id_pkg::K_NONE);
        end
      end
      c8id_pkg::GRP_JP: begin
        dec_o     = mk(c8id_pkg::OP_GOTO, c8id_pkg::K_ADDR, c8id_pkg::K_NONE, c8id_pkg::K_NONE);
        dec_o.imm = nnn;
      end
      c8id_pkg::GRP_CALL: begin
        dec_o     = mk(c8id_pkg::OP_CALL, c8id_pkg::K_ADDR, c8id_pkg::K_NONE, c8id_pkg::K_NONE);
        dec_o.imm = nnn;
      end
      c8id_pkg::GRP_SEK: begin
        dec_o     = mk(c8id_pkg::OP_SKE, c8id_pkg::K_REG, c8id_pkg::K_CONST, c8id_pkg::K_NONE);
        dec_o.x   = x;
        dec_o.imm = {4'd0, kk};
      end
      c8id_pkg::GRP_SNEK: begin
        dec_o     = mk(c8id_pkg::OP_SKNE, c8id_pkg::K_REG, c8id_pkg::K_CONST, c8id_pkg::K_NONE);
        dec_o.x   = x;
        dec_o.imm = {4'd0, kk};
      end
      c8id_pkg::GRP_SER: begin
        dec_o   = mk(c8id_pkg::OP_SKE, c8id_pkg::K_REG, c8id_pkg::K_REG, c8id_pkg::K_NONE);
        dec_o.x = x;
        dec_o.y = y;
      end
      c8id_pkg::GRP_LDK: begin
        dec_o     = mk(c8id_pkg::OP_COPY, c8id_pkg::K_REG, c8id_pkg::K_CONST, c8id_pkg::K_NONE);
        dec_o.x   = x;
        dec_o.imm = {4'd0, kk};
      end
      c8id_pkg::GRP_ADDK: begin
        dec_o     = mk(c8id_pkg::OP_ADD, c8id_pkg::K_REG, c8id_pkg::K_CONST, c8id_pkg::K_NONE);
        dec_o.x   = x;
        dec_o.imm = {4'd0, kk};
      end
      c8id_pkg::GRP_ALU: begin
        unique case (n)
          c8id_pkg::ALU_MOV: dec_o = mk(c8id_pkg::OP_COPY, c8id_pkg::K_REG, c8id_pkg::K_REG,
                                        c8id_pkg::K_NONE);
          c8id_pkg::ALU_OR:  dec_o = mk(c8id_pkg::OP_OR, c8id_pkg::K_REG, c8id_pkg::K_REG,
                                        c8id_pkg::K_NONE);
          c8id_pkg::ALU_AND: dec_o = mk(c8id_pkg::OP_AND, c8id_pkg::K_REG, c8id_pkg::K_REG,
                                        c8id_pkg::K_NONE);
          c8id_pkg::ALU_XOR: dec_o = mk(c8id_pkg::OP_XOR, c8id_pkg::K_REG, c8id_pkg::K_REG,
                                        c8id_pkg::K_NONE);
          c8id_pkg::ALU_ADD: dec_o = mk(c8id_pkg::OP_ADD, c8id_pkg::K_REG, c8id_pkg::K_REG,
                                        c8id_pkg::K_NONE);
          c8id_pkg::ALU_SUB: dec_o = mk(c8id_pkg::OP_SUB, c8id_pkg::K_REG, c8id_pkg::K_REG,
                                        c8id_pkg::K_NONE);
          default:           dec_o = c8id_pkg::DEC_NONE;
        endcase
        if (dec_o.valid) begin
          dec_o.x = x;
          dec_o.y = y;
        end
      end
      c8id_pkg::GRP_SNER: begin
        dec_o   = mk(c8id_pkg::OP_SKNE, c8id_pkg::K_REG, c8id_pkg::K_REG, c8id_pkg::K_NONE);
        dec_o.x = x;
        dec_o.y = y;
      end
      c8id_pkg::GRP_LDI: begin
        dec_o     = mk(c8id_pkg::OP_SETI, c8id_pkg::K_I, c8id_pkg::K_CONST, c8id_pkg::K_NONE);
        dec_o.imm = nnn;
      end
      c8id_pkg::GRP_JPV0: begin
        // V0 base: reg_y stays 0
        dec_o     = mk(c8id_pkg::OP_GOTOREL, c8id_pkg::K_CONST, c8id_pkg::K_REG,
                       c8id_pkg::K_NONE);
        dec_o.imm = nnn;
      end
      c8id_pkg::GRP_RND: begin
        dec_o     = mk(c8id_pkg::OP_RAND, c8id_pkg::K_REG, c8id_pkg::K_CONST, c8id_pkg::K_NONE);
        dec_o.x   = x;
        dec_o.imm = {4'd0, kk};
      end
      c8id_pkg::GRP_DRW: begin
        dec_o     = mk(c8id_pkg::OP_SHOW, c8id_pkg::K_CONST, c8id_pkg::K_REG, c8id_pkg::K_REG);
        dec_o.x   = x;
        dec_o.y   = y;
        dec_o.imm = {8'd0, n};
      end
      c8id_pkg::GRP_KEY: begin
        unique case (kk)
          c8id_pkg::LB_SKP:  dec_o = mk(c8id_pkg::OP_SKE_KEY, c8id_pkg::K_REG, c8id_pkg::K_KEY,
                                        c8id_pkg::K_NONE);
          c8id_pkg::LB_SKNP: dec_o = mk(c8id_pkg::OP_SKNE_KEY, c8id_pkg::K_REG, c8id_pkg::K_KEY,
                                        c8id_pkg::K_NONE);
          default:           dec_o = c8id_pkg::DEC_NONE;
        endcase
        if (dec_o.valid) begin
          dec_o.x = x;
        end
      end
      default: begin
        // group F
        unique case (kk)
          c8id_pkg::LB_GDT:   dec_o = mk(c8id_pkg::OP_GETTIME, c8id_pkg::K_REG,
                                         c8id_pkg::K_TIME, c8id_pkg::K_NONE);
          c8id_pkg::LB_GKEY:  dec_o = mk(c8id_pkg::OP_GETKEY, c8id_pkg::K_REG,
                                         c8id_pkg::K_KEY, c8id_pkg::K_NONE);
          c8id_pkg::LB_SDT:   dec_o = mk(c8id_pkg::OP_SETTIME, c8id_pkg::K_TIME,
                                         c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_PITCH: dec_o = mk(c8id_pkg::OP_SETPITCH, c8id_pkg::K_PITCH,
                                         c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_TONE:  dec_o = mk(c8id_pkg::OP_SETTONE, c8id_pkg::K_TONE,
                                         c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_ADDI:  dec_o = mk(c8id_pkg::OP_ADD, c8id_pkg::K_I,
                                         c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_DIGIT: dec_o = mk(c8id_pkg::OP_COPY2, c8id_pkg::K_MI,
                                         c8id_pkg::K_DIGIT, c8id_pkg::K_REG);
          c8id_pkg::LB_BCD:   dec_o = mk(c8id_pkg::OP_COPY2, c8id_pkg::K_MI,
                                         c8id_pkg::K_DEC, c8id_pkg::K_REG);
          c8id_pkg::LB_STORE: dec_o = mk(c8id_pkg::OP_COPY, c8id_pkg::K_MI,
                                         c8id_pkg::K_RANGE, c8id_pkg::K_NONE);
          c8id_pkg::LB_LOAD:  dec_o = mk(c8id_pkg::OP_COPY, c8id_pkg::K_RANGE,
                                         c8id_pkg::K_MI, c8id_pkg::K_NONE);
          c8id_pkg::LB_TX485: dec_o = mk(c8id_pkg::OP_COPY, c8id_pkg::K_RS485,
                                         c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_RX485: dec_o = mk(c8id_pkg::OP_COPY, c8id_pkg::K_REG,
                                         c8id_pkg::K_RS485, c8id_pkg::K_NONE);
          c8id_pkg::LB_BAUD:  dec_o = mk(c8id_pkg::OP_COPY, c8id_pkg::K_BAUD,
                                         c8id_pkg::K_REG, c8id_pkg::K_NONE);
          default:            dec_o = c8id_pkg::DEC_NONE;
        endcase
        if (dec_o.valid) begin
          dec_o.x = x;
        end
      end
    endcase
  end

endmodule

// ===== rtl/chip8_instruction_decoder.sv =====
// Top level of the extended CHIP-8 instruction decoder.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Decodes one 16-bit instruction word per item into a valid flag, a dense
// operation class, three operand kinds, the X and Y register numbers and a
// 12-bit immediate (kk, nnn or sprite height n). An item is taken at any
// clock edge with start_i high; busy_o is always low, so a new word can be
// given every cycle. The word is registered, decoded by short combinational
// logic and the result registered again; res_strobe_o comes from the result
// register and stays high for one cycle. The receiver cannot stall, and
// needs none: a result is shown for exactly one cycle and one result leaves
// per cycle, the same rate items come in.
// Unrecognized encodings give valid_res_o low and every other field zero.
// No state other than the two pipeline stages is kept.
module chip8_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] instr_word_i,
  output logic        res_strobe_o,
  output logic        valid_res_o,
  output logic [4:0]  operation_o,
  output logic [3:0]  kind_first_o,
  output logic [3:0]  kind_second_o,
  output logic [3:0]  kind_third_o,
  output logic [3:0]  reg_x_o,
  output logic [3:0]  reg_y_o,
  output logic [11:0] immediate_o
);

  logic           in_vld_q, in_vld_d;
  logic [15:0]    word_q;
  logic           res_vld_q, res_vld_d;
  c8id_pkg::dec_t res_q;
  c8id_pkg::dec_t dec;
  logic           take;

  // Nothing ever backs up: the receiver takes every result.
  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;

  assign in_vld_d  = take;
  assign res_vld_d = in_vld_q;

  // Stage 1: input word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= instr_word_i;
    end
  end

  c8id_decode u_decode (
    .word_i (word_q),
    .dec_o  (dec)
  );

  // Stage 2: result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= dec;
    end
  end

  assign res_strobe_o  = res_vld_q;
  assign valid_res_o   = res_q.valid;
  assign operation_o   = res_q.op;
  assign kind_first_o  = res_q.k0;
  assign kind_second_o = res_q.k1;
  assign kind_third_o  = res_q.k2;
  assign reg_x_o       = res_q.x;
  assign reg_y_o       = res_q.y;
  assign immediate_o   = res_q.imm;

  // Every taken item fills stage 1, and only a taken item does.
  `C8ID_ASSERT_NEXT(a_take_fills, take, in_vld_q, "taken item did not reach stage 1")
  `C8ID_ASSERT_NEXT(a_idle_empty, !take, !in_vld_q, "stage 1 filled without an item")
  // Stage 1 always drains into a result in the next cycle.
  `C8ID_ASSERT_NEXT(a_stage_out, in_vld_q, res_strobe_o, "decoded item lost")
  // An unrecognized word carries an all-zero result.
  `C8ID_ASSERT(a_inval_zero, !(res_strobe_o && !valid_res_o) ||
    (operation_o == c8id_pkg::OP_NOP && kind_first_o == c8id_pkg::K_NONE &&
     kind_second_o == c8id_pkg::K_NONE && kind_third_o == c8id_pkg::K_NONE &&
     reg_x_o == 4'd0 && reg_y_o == 4'd0 && immediate_o == 12'd0),
    "invalid result has nonzero fields")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the CHIP-8 instruction decoder.
`timescale 1ns / 1ps
module testbench;

  // Cycles with neither an accepted item nor a result before the run is aborted.
  localparam int unsigned QUIET_LIMIT = 1000;
  // Pipeline depth is two registers; a few spare cycles at the tail.
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 250;

  // One row of the directed table. When 'typed' is set, 'want' is the result
  // read straight off the decode rules; otherwise the predictor supplies it.
  typedef struct packed {
    logic [15:0]    word;
    logic           typed;
    c8id_pkg::dec_t want;
  } stim_row_t;

  localparam c8id_pkg::dec_t NOP_DEC = '{
    valid: 1'b1, op: c8id_pkg::OP_NOP, k0: c8id_pkg::K_NONE, k1: c8id_pkg::K_NONE,
    k2: c8id_pkg::K_NONE, x: 4'd0, y: 4'd0, imm: 12'd0
  };
  localparam c8id_pkg::dec_t CLS_DEC = '{
    valid: 1'b1, op: c8id_pkg::OP_ERASE, k0: c8id_pkg::K_NONE, k1: c8id_pkg::K_NONE,
    k2: c8id_pkg::K_NONE, x: 4'd0, y: 4'd0, imm: 12'd0
  };
  localparam c8id_pkg::dec_t RET_DEC = '{
    valid: 1'b1, op: c8id_pkg::OP_RETURN, k0: c8id_pkg::K_NONE, k1: c8id_pkg::K_NONE,
    k2: c8id_pkg::K_NONE, x: 4'd0, y: 4'd0, imm: 12'd0
  };
  localparam c8id_pkg::dec_t BAD_DEC = c8id_pkg::DEC_NONE;

  // Directed words: field extremes, every operation class and the odd cases
  // (a stray group-0 word, ALU sub-code above 5, bad E-group low byte, skip
  // forms with a nonzero low nibble, 4xkk against a constant).
  localparam int unsigned N_DIRECTED = 30;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{16'h0000, 1'b1, NOP_DEC},   // all zeros: nop
    '{16'hFFFF, 1'b1, BAD_DEC},   // all ones: Fx with low byte FF, invalid
    '{16'h00E0, 1'b1, CLS_DEC},
    '{16'h00EE, 1'b1, RET_DEC},
    '{16'h0001, 1'b1, BAD_DEC},   // group 0, not one of the three known words
    '{16'h1FFF, 1'b0, BAD_DEC},
    '{16'h2ABC, 1'b0, BAD_DEC},
    '{16'h4F00, 1'b0, BAD_DEC},   // skip-not-equal against constant kk
    '{16'h5AB7, 1'b0, BAD_DEC},   // skip-equal, low nibble ignored
    '{16'h6123, 1'b0, BAD_DEC},
    '{16'h7FF0, 1'b0, BAD_DEC},
    '{16'h8121, 1'b0, BAD_DEC},
    '{16'h8232, 1'b0, BAD_DEC},
    '{16'h8343, 1'b0, BAD_DEC},
    '{16'h8F15, 1'b0, BAD_DEC},
    '{16'h8F16, 1'b1, BAD_DEC},   // ALU sub-code past subtract
    '{16'h9CDF, 1'b0, BAD_DEC},   // skip-not-equal, low nibble ignored
    '{16'hA800, 1'b0, BAD_DEC},
    '{16'hBFFF, 1'b0, BAD_DEC},
    '{16'hCC3A, 1'b0, BAD_DEC},
    '{16'hDFFF, 1'b0, BAD_DEC},
    '{16'hE39E, 1'b0, BAD_DEC},
    '{16'hEAA1, 1'b0, BAD_DEC},
    '{16'hE09F, 1'b1, BAD_DEC},   // key group, unknown low byte
    '{16'hF107, 1'b0, BAD_DEC},
    '{16'hF20A, 1'b0, BAD_DEC},
    '{16'hF315, 1'b0, BAD_DEC},
    '{16'hF417, 1'b0, BAD_DEC},
    '{16'hF518, 1'b0, BAD_DEC},
    '{16'hF629, 1'b0, BAD_DEC}
  };

  // Low bytes that the F group recognizes; used to build well-formed words.
  localparam logic [7:0] F_CODES [13] = '{
    c8id_pkg::LB_GDT, c8id_pkg::LB_GKEY, c8id_pkg::LB_SDT, c8id_pkg::LB_PITCH,
    c8id_pkg::LB_TONE, c8id_pkg::LB_ADDI, c8id_pkg::LB_DIGIT, c8id_pkg::LB_BCD,
    c8id_pkg::LB_STORE, c8id_pkg::LB_LOAD, c8id_pkg::LB_TX485, c8id_pkg::LB_RX485,
    c8id_pkg::LB_BAUD
  };
  localparam logic [15:0] SYS_WORDS [3] = '{
    c8id_pkg::W_NOP, c8id_pkg::W_CLS, c8id_pkg::W_RET
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [15:0] instr_word_i;
  logic        res_strobe_o;
  logic        valid_res_o;
  logic [4:0]  operation_o;
  logic [3:0]  kind_first_o;
  logic [3:0]  kind_second_o;
  logic [3:0]  kind_third_o;
  logic [3:0]  reg_x_o;
  logic [3:0]  reg_y_o;
  logic [11:0] immediate_o;

  c8id_pkg::dec_t pending_decodes [$];  // expected results, oldest first
  int unsigned    error_count = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    sender_idle_pct = 0;

  chip8_instruction_decoder uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .instr_word_i (instr_word_i),
    .res_strobe_o (res_strobe_o),
    .valid_res_o  (valid_res_o),
    .operation_o  (operation_o),
    .kind_first_o (kind_first_o),
    .kind_second_o(kind_second_o),
    .kind_third_o (kind_third_o),
    .reg_x_o      (reg_x_o),
    .reg_y_o      (reg_y_o),
    .immediate_o  (immediate_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Recognized encoding with its operation class and operand kinds; the
  // register and immediate fields start at zero and are filled by the caller.
  function automatic c8id_pkg::dec_t classify(c8id_pkg::op_e op, c8id_pkg::kind_e a,
                                              c8id_pkg::kind_e b, c8id_pkg::kind_e c);
    c8id_pkg::dec_t d;
    d = c8id_pkg::DEC_NONE;
    d.valid = 1'b1;
    d.op = op;
    d.k0 = a;
    d.k1 = b;
    d.k2 = c;
    return d;
  endfunction

  // Predicts the decoder output for one instruction word.
  function automatic c8id_pkg::dec_t decode_expect(logic [15:0] w);
    c8id_pkg::dec_t d;
    logic [3:0]     rx;
    logic [3:0]     ry;
    logic [3:0]     n;
    logic [7:0]     kk;
    rx = w[11:8];
    ry = w[7:4];
    n  = w[3:0];
    kk = w[7:0];
    d  = c8id_pkg::DEC_NONE;
    case (w[15:12])
      c8id_pkg::GRP_SYS: begin
        if (w == c8id_pkg::W_NOP) begin
          d = classify(c8id_pkg::OP_NOP, c8id_pkg::K_NONE, c8id_pkg::K_NONE, c8id_pkg::K_NONE);
        end else if (w == c8id_pkg::W_CLS) begin
          d = classify(c8id_pkg::OP_ERASE, c8id_pkg::K_NONE, c8id_pkg::K_NONE,
                       c8id_pkg::K_NONE);
        end else if (w == c8id_pkg::W_RET) begin
          d = classify(c8id_pkg::OP_RETURN, c8id_pkg::K_NONE, c8id_pkg::K_NONE,
                       c8id_pkg::K_NONE);
        end
      end
      c8id_pkg::GRP_JP: begin
        d = classify(c8id_pkg::OP_GOTO, c8id_pkg::K_ADDR, c8id_pkg::K_NONE, c8id_pkg::K_NONE);
        d.imm = w[11:0];
      end
      c8id_pkg::GRP_CALL: begin
        d = classify(c8id_pkg::OP_CALL, c8id_pkg::K_ADDR, c8id_pkg::K_NONE, c8id_pkg::K_NONE);
        d.imm = w[11:0];
      end
      c8id_pkg::GRP_SEK, c8id_pkg::GRP_SNEK, c8id_pkg::GRP_LDK, c8id_pkg::GRP_ADDK,
      c8id_pkg::GRP_RND: begin
        case (w[15:12])
          c8id_pkg::GRP_SEK:  d.op = c8id_pkg::OP_SKE;
          c8id_pkg::GRP_SNEK: d.op = c8id_pkg::OP_SKNE;
          c8id_pkg::GRP_LDK:  d.op = c8id_pkg::OP_COPY;
          c8id_pkg::GRP_ADDK: d.op = c8id_pkg::OP_ADD;
          default:            d.op = c8id_pkg::OP_RAND;
        endcase
        d = classify(d.op, c8id_pkg::K_REG, c8id_pkg::K_CONST, c8id_pkg::K_NONE);
        d.x = rx;
        d.imm = {4'd0, kk};
      end
      c8id_pkg::GRP_SER, c8id_pkg::GRP_SNER: begin
        d = classify((w[15:12] == c8id_pkg::GRP_SER) ? c8id_pkg::OP_SKE : c8id_pkg::OP_SKNE,
                     c8id_pkg::K_REG, c8id_pkg::K_REG, c8id_pkg::K_NONE);
        d.x = rx;
        d.y = ry;
      end
      c8id_pkg::GRP_ALU: begin
        d.valid = 1'b1;
        case (n)
          c8id_pkg::ALU_MOV: d.op = c8id_pkg::OP_COPY;
          c8id_pkg::ALU_OR:  d.op = c8id_pkg::OP_OR;
          c8id_pkg::ALU_AND: d.op = c8id_pkg::OP_AND;
          c8id_pkg::ALU_XOR: d.op = c8id_pkg::OP_XOR;
          c8id_pkg::ALU_ADD: d.op = c8id_pkg::OP_ADD;
          c8id_pkg::ALU_SUB: d.op = c8id_pkg::OP_SUB;
          default:           d.valid = 1'b0;
        endcase
        if (d.valid) begin
          d = classify(d.op, c8id_pkg::K_REG, c8id_pkg::K_REG, c8id_pkg::K_NONE);
          d.x = rx;
          d.y = ry;
        end else begin
          d = c8id_pkg::DEC_NONE;
        end
      end
      c8id_pkg::GRP_LDI: begin
        d = classify(c8id_pkg::OP_SETI, c8id_pkg::K_I, c8id_pkg::K_CONST, c8id_pkg::K_NONE);
        d.imm = w[11:0];
      end
      c8id_pkg::GRP_JPV0: begin
        // base register is always V0, so reg_y stays zero
        d = classify(c8id_pkg::OP_GOTOREL, c8id_pkg::K_CONST, c8id_pkg::K_REG,
                     c8id_pkg::K_NONE);
        d.imm = w[11:0];
      end
      c8id_pkg::GRP_DRW: begin
        d = classify(c8id_pkg::OP_SHOW, c8id_pkg::K_CONST, c8id_pkg::K_REG, c8id_pkg::K_REG);
        d.x = rx;
        d.y = ry;
        d.imm = {8'd0, n};
      end
      c8id_pkg::GRP_KEY: begin
        if (kk == c8id_pkg::LB_SKP) begin
          d = classify(c8id_pkg::OP_SKE_KEY, c8id_pkg::K_REG, c8id_pkg::K_KEY,
                       c8id_pkg::K_NONE);
        end else if (kk == c8id_pkg::LB_SKNP) begin
          d = classify(c8id_pkg::OP_SKNE_KEY, c8id_pkg::K_REG, c8id_pkg::K_KEY,
                       c8id_pkg::K_NONE);
        end
        if (d.valid) d.x = rx;
      end
      default: begin
        case (kk)
          c8id_pkg::LB_GDT:   d = classify(c8id_pkg::OP_GETTIME, c8id_pkg::K_REG,
                                           c8id_pkg::K_TIME, c8id_pkg::K_NONE);
          c8id_pkg::LB_GKEY:  d = classify(c8id_pkg::OP_GETKEY, c8id_pkg::K_REG,
                                           c8id_pkg::K_KEY, c8id_pkg::K_NONE);
          c8id_pkg::LB_SDT:   d = classify(c8id_pkg::OP_SETTIME, c8id_pkg::K_TIME,
                                           c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_PITCH: d = classify(c8id_pkg::OP_SETPITCH, c8id_pkg::K_PITCH,
                                           c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_TONE:  d = classify(c8id_pkg::OP_SETTONE, c8id_pkg::K_TONE,
                                           c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_ADDI:  d = classify(c8id_pkg::OP_ADD, c8id_pkg::K_I,
                                           c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_DIGIT: d = classify(c8id_pkg::OP_COPY2, c8id_pkg::K_MI,
                                           c8id_pkg::K_DIGIT, c8id_pkg::K_REG);
          c8id_pkg::LB_BCD:   d = classify(c8id_pkg::OP_COPY2, c8id_pkg::K_MI,
                                           c8id_pkg::K_DEC, c8id_pkg::K_REG);
          c8id_pkg::LB_STORE: d = classify(c8id_pkg::OP_COPY, c8id_pkg::K_MI,
                                           c8id_pkg::K_RANGE, c8id_pkg::K_NONE);
          c8id_pkg::LB_LOAD:  d = classify(c8id_pkg::OP_COPY, c8id_pkg::K_RANGE,
                                           c8id_pkg::K_MI, c8id_pkg::K_NONE);
          c8id_pkg::LB_TX485: d = classify(c8id_pkg::OP_COPY, c8id_pkg::K_RS485,
                                           c8id_pkg::K_REG, c8id_pkg::K_NONE);
          c8id_pkg::LB_RX485: d = classify(c8id_pkg::OP_COPY, c8id_pkg::K_REG,
                                           c8id_pkg::K_RS485, c8id_pkg::K_NONE);
          c8id_pkg::LB_BAUD:  d = classify(c8id_pkg::OP_COPY, c8id_pkg::K_BAUD,
                                           c8id_pkg::K_REG, c8id_pkg::K_NONE);
          default:            d = c8id_pkg::DEC_NONE;
        endcase
        if (d.valid) d.x = rx;
      end
    endcase
    return d;
  endfunction

  // Mostly well-formed words with random register and immediate content;
  // one in five is a fully random word, which can be an invalid 0/8/E/F code.
  function automatic logic [15:0] random_word();
    logic [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(0, 99) < 80) begin
      case (w[15:12])
        c8id_pkg::GRP_SYS: w = SYS_WORDS[$urandom_range(0, 2)];
        c8id_pkg::GRP_ALU: w[3:0] = 4'($urandom_range(0, 5));
        c8id_pkg::GRP_KEY: w[7:0] = ($urandom_range(0, 1) != 0) ? c8id_pkg::LB_SKP
                                                                 : c8id_pkg::LB_SKNP;
        c8id_pkg::GRP_LDI, c8id_pkg::GRP_JP, c8id_pkg::GRP_CALL, c8id_pkg::GRP_SEK,
        c8id_pkg::GRP_SNEK, c8id_pkg::GRP_SER, c8id_pkg::GRP_LDK, c8id_pkg::GRP_ADDK,
        c8id_pkg::GRP_SNER, c8id_pkg::GRP_JPV0, c8id_pkg::GRP_RND, c8id_pkg::GRP_DRW: ;
        default: w[7:0] = F_CODES[$urandom_range(0, 12)];
      endcase
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    error_count++;
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Offers one item, with random idle cycles ahead of it, and records its
  // expected decode once the handshake completes. Called at a rising edge.
  task automatic send_word(logic [15:0] w, logic typed, c8id_pkg::dec_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    instr_word_i <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_decodes.push_back(typed ? want : decode_expect(w));
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_decodes.size() != 0) @(posedge clk_i);
  endtask

  // Result checker: every strobed result is matched against the oldest
  // outstanding expectation, field by field.
  always @(posedge clk_i) begin
    c8id_pkg::dec_t want;
    if (rst_ni && res_strobe_o) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected result", operation_o, 0);
      end else begin
        want = pending_decodes.pop_front();
        check_field("valid_res", valid_res_o, want.valid);
        check_field("operation", operation_o, want.op);
        check_field("kind_first", kind_first_o, want.k0);
        check_field("kind_second", kind_second_o, want.k1);
        check_field("kind_third", kind_third_o, want.k2);
        check_field("reg_x", reg_x_o, want.x);
        check_field("reg_y", reg_y_o, want.y);
        check_field("immediate", immediate_o, want.imm);
      end
    end
  end

  // Watchdog: any accepted item or result restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || res_strobe_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned phase_idle [3];
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    instr_word_i = 16'h0000;
    // Idle percentages per random phase: back to back, heavy gaps, light gaps.
    phase_idle = '{0, 46, 29};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, back to back.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
    end
    // Sender waits for the pipeline to empty before the random part.
    drain_results();

    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = phase_idle[p];
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_word(random_word(), 1'b0, c8id_pkg::DEC_NONE);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/c8id_pkg.sv
rtl/c8id_decode.sv
rtl/chip8_instruction_decoder.sv
verif/testbench.sv
